[rtl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

	localparam int COORD_W     = 11;
	localparam int RADIUS_W    = 7;
	localparam int COLOR_W     = 8;
	localparam int GRID_W      = 11;
	localparam int MASK_W      = 8;
	localparam int STEP_CNT_W  = 6;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	localparam logic [RADIUS_W-1:0]   MAX_RADIUS  = 7'd88;
	localparam logic [STEP_CNT_W-1:0] STEP_LAST   = 6'd63;
	localparam logic [GRID_W-1:0]     GRID_W_RST  = 11'd400;
	localparam logic [GRID_W-1:0]     GRID_H_RST  = 11'd300;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RADIUS_W-1:0]       radius;
		logic [COLOR_W-1:0]        color_code;
	} circle_t;

endpackage

[rtl/mcr_front.sv]
// Input stage: unpacks a circle word, saturates the radius, registers it for the queue.
module mcr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mcr_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           push_valid,
	input  logic                           push_ready,
	output mcr_pkg::circle_t               push_item
);
	import mcr_pkg::*;

	logic    valid_q;
	circle_t item_q;
	circle_t item_d;
	logic [RADIUS_W-1:0] radius_in;

	always_comb begin
		radius_in           = s_tdata[28:22];
		item_d.center_x     = $signed(s_tdata[10:0]);
		item_d.center_y     = $signed(s_tdata[21:11]);
		item_d.radius       = (radius_in > MAX_RADIUS) ? MAX_RADIUS : radius_in;
		item_d.color_code   = s_tdata[36:29];
	end

	assign s_tready   = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= item_d;
		end
	end

endmodule

[rtl/mcr_queue.sv]
// Short circle queue between the input stage and the octant walker.
module mcr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  mcr_pkg::circle_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output mcr_pkg::circle_t pop_item
);
	import mcr_pkg::*;

	circle_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/mcr_back.sv]
// Octant walker: midpoint decision update, grid mask and output register.
module mcr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  mcr_pkg::circle_t                pop_item,
	input  logic [mcr_pkg::GRID_W-1:0]      grid_width,
	input  logic [mcr_pkg::GRID_W-1:0]      grid_height,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mcr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import mcr_pkg::*;

	function automatic logic on_grid(logic signed [COORD_W:0] px, logic signed [COORD_W:0] py,
			logic [GRID_W-1:0] gw, logic [GRID_W-1:0] gh);
		logic ok;
		ok = !px[COORD_W] && !py[COORD_W] && (px[COORD_W-1:0] < gw) && (py[COORD_W-1:0] < gh);
		return ok;
	endfunction

	// walker state
	logic                      active_q;
	logic [RADIUS_W-1:0]       x_q;
	logic [RADIUS_W-1:0]       y_q;
	logic signed [10:0]        d_q;
	logic [STEP_CNT_W-1:0]     cnt_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [COLOR_W-1:0]        color_q;

	// output register
	logic                      m_tvalid_q;
	logic [OUT_TDATA_W-1:0]    m_tdata_q;
	logic                      m_tlast_q;

	logic                      adv;
	logic                      pop;
	logic signed [8:0]         x1;
	logic signed [8:0]         y1;
	logic signed [8:0]         diff;
	logic signed [10:0]        d_next;
	logic                      last_w;
	logic signed [COORD_W:0]   cx_e, cy_e, ox_e, oy_e;
	logic signed [COORD_W:0]   cxpx, cxmx, cxpy, cxmy, cypx, cymx, cypy, cymy;
	logic [MASK_W-1:0]         mask;

	always_comb begin
		adv       = active_q && (!m_tvalid_q || m_tready);
		pop_ready = !active_q;
		pop       = pop_valid && pop_ready;

		x1   = $signed({2'b00, x_q}) + 9'sd1;
		y1   = (d_q > 11'sd0) ? ($signed({2'b00, y_q}) - 9'sd1) : $signed({2'b00, y_q});
		diff = x1 - y1;
		if (d_q > 11'sd0) begin
			d_next = d_q + $signed({diff, 2'b00}) + 11'sd10;
		end else begin
			d_next = d_q + $signed({x1, 2'b00}) + 11'sd6;
		end
		last_w = (y1 < x1) || (cnt_q == STEP_LAST);

		cx_e = {cx_q[COORD_W-1], cx_q};
		cy_e = {cy_q[COORD_W-1], cy_q};
		ox_e = $signed({5'b00000, x_q});
		oy_e = $signed({5'b00000, y_q});
		cxpx = cx_e + ox_e;
		cxmx = cx_e - ox_e;
		cxpy = cx_e + oy_e;
		cxmy = cx_e - oy_e;
		cypx = cy_e + ox_e;
		cymx = cy_e - ox_e;
		cypy = cy_e + oy_e;
		cymy = cy_e - oy_e;

		mask[0] = on_grid(cxpx, cypy, grid_width, grid_height);
		mask[1] = on_grid(cxmx, cypy, grid_width, grid_height);
		mask[2] = on_grid(cxpx, cymy, grid_width, grid_height);
		mask[3] = on_grid(cxmx, cymy, grid_width, grid_height);
		mask[4] = on_grid(cxpy, cypx, grid_width, grid_height);
		mask[5] = on_grid(cxmy, cypx, grid_width, grid_height);
		mask[6] = on_grid(cxpy, cymx, grid_width, grid_height);
		mask[7] = on_grid(cxmy, cymx, grid_width, grid_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (adv && last_w) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q     <= '0;
			y_q     <= pop_item.radius;
			d_q     <= 11'sd3 - $signed({3'b000, pop_item.radius, 1'b0});
			cnt_q   <= '0;
			cx_q    <= pop_item.center_x;
			cy_q    <= pop_item.center_y;
			color_q <= pop_item.color_code;
		end else if (adv) begin
			x_q   <= x1[RADIUS_W-1:0];
			y_q   <= y1[RADIUS_W-1:0];
			d_q   <= d_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (adv) begin
			m_tdata_q <= {2'b00, color_q, mask, y_q, x_q};
			m_tlast_q <= last_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// walk stays in the first octant while running
	a_octant: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (y_q >= x_q))
		else $error("walker left the octant");

	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (x_q <= 7'd63))
		else $error("x offset beyond step limit");

	a_d_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((d_q > -11'sd400) && (d_q < 11'sd400)))
		else $error("decision value out of range");

	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> (m_tvalid_q && m_tlast_q))
		else $error("circle ended without a final word");

endmodule

[rtl/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer: config registers, front, queue, walker.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one circle: center_x, center_y, radius, color
//  m_*     | out | m_tvalid/m_tready  | one octant step: x, y, mask, color; tlast=final
//  cfg_*   | in  | cfg_valid/cfg_ready| grid_width (index 0) or grid_height (index 1)
//
//  A circle of radius r gives about r/sqrt(2)+1 output words, at most 64 (63 for r = 88).
//  The walker emits one word per cycle while m_tready does not stall it, and takes a
//  new circle only after the final word of the previous one has been registered.
//  Reset sets grid_width to 400 and grid_height to 300 and empties the queue.
//  Low m_tready freezes the walker once an output word is waiting; the input register
//  and a 4-deep queue keep taking circles meanwhile until full. cfg_ready is always high.
module midpoint_circle_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [10:0] center_x, [21:11] center_y, [28:22] radius, [36:29] color_code, [39:37] zero
	input  logic [mcr_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [6:0] step_x, [13:7] step_y, [21:14] on_grid_mask, [29:22] paint_color, [31:30] zero
	output logic [mcr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast,   // last_step
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mcr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mcr_pkg::GRID_W-1:0]      cfg_data
);
	import mcr_pkg::*;

	logic [GRID_W-1:0] grid_width_q;
	logic [GRID_W-1:0] grid_height_q;

	logic    push_valid, push_ready;
	circle_t push_item;
	logic    pop_valid, pop_ready;
	circle_t pop_item;

	assign cfg_ready = 1'b1;

	// grid registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_W_RST;
			grid_height_q <= GRID_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
